// File: rtl/mtpd_pkg.sv
// ----------------------------------------------------------------------------
// mtpd_pkg
// Shared constants, types and helpers for the minimum two-way partition
// difference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtpd_pkg;

    // Set size and value widths
    localparam int MAX_VALUES = 10;
    localparam int VALUE_BITS = 16;
    localparam int IN_BITS    = 16;
    localparam int OUT_BITS   = 20;

    localparam int STORE_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
    localparam int CNT_BITS   = $clog2(MAX_VALUES + 1);
    localparam int IDX_BITS   = $clog2(MAX_VALUES);
    localparam int SUM_BITS   = $clog2(MAX_VALUES) + STORE_BITS;
    localparam int DIFF_BITS  = SUM_BITS + 1;
    localparam int MASK_BITS  = MAX_VALUES - 1;
    localparam int WIDE_BITS  = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;

    localparam logic [OUT_BITS-1:0]  OUT_MAX   = '1;
    localparam logic [MASK_BITS-1:0] MASK_ONES = '1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Value write into one cell of the chain
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic [STORE_BITS-1:0] value;
    } t_load;

    // Split under evaluation, moving one cell per cycle
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [MAX_VALUES-1:0] mask;   // bit 0 is the split bit of the current cell
        logic [DIFF_BITS-1:0]  diff;   // two's complement, group one minus group two
    } t_token;

    // Clamp a sum to the result width
    function automatic logic [OUT_BITS-1:0] sat_out(input logic [SUM_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        if (w > WIDE_BITS'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return OUT_BITS'(w);
    endfunction

endpackage

`default_nettype wire

// File: rtl/mtpd_cell.sv
// ----------------------------------------------------------------------------
// mtpd_cell
// One chain cell: holds one loaded value and adds it to, or subtracts it
// from, the passing split difference.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpd_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [mtpd_pkg::STORE_BITS-1:0] i_wr_value,
    input  wire logic                          i_active,
    input  wire mtpd_pkg::t_token              i_tok,
    output mtpd_pkg::t_token                   o_tok
);

    logic [mtpd_pkg::STORE_BITS-1:0] r_value;
    logic [mtpd_pkg::DIFF_BITS-1:0]  w_ext;
    mtpd_pkg::t_token                n_tok;
    mtpd_pkg::t_token                r_tok;

    // Stored value
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_value <= i_wr_value;
        end
    end

    // Add for group one, subtract for group two; unused cells pass through
    always_comb begin
        w_ext = mtpd_pkg::DIFF_BITS'(r_value);
        n_tok = i_tok;
        n_tok.mask = i_tok.mask >> 1;
        if (i_active) begin
            if (i_tok.mask[0]) begin
                n_tok.diff = i_tok.diff - w_ext;
            end else begin
                n_tok.diff = i_tok.diff + w_ext;
            end
        end
    end

    // Token register; only valid is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.last <= n_tok.last;
        r_tok.mask <= n_tok.mask;
        r_tok.diff <= n_tok.diff;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/mtpd_seq.sv
// ----------------------------------------------------------------------------
// mtpd_seq
// Sequencer: loads values, walks all splits into the cell chain, keeps the
// smallest difference and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpd_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [mtpd_pkg::IN_BITS-1:0]    i_value,
    input  wire logic                            i_last,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [mtpd_pkg::OUT_BITS-1:0]        o_min_difference,
    output logic [mtpd_pkg::OUT_BITS-1:0]        o_total_sum,
    output logic                                 o_no_partition,
    output logic                                 o_count_overflow,
    // chain side
    output mtpd_pkg::t_load                      o_load,
    output logic [mtpd_pkg::MAX_VALUES-1:0]      o_active,
    output mtpd_pkg::t_token                     o_tok,
    input  wire mtpd_pkg::t_token                i_tok
);

    mtpd_pkg::t_state                r_state, n_state;
    logic [mtpd_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic [mtpd_pkg::SUM_BITS-1:0]   r_total, n_total;
    logic                            r_ovf, n_ovf;
    logic [mtpd_pkg::MAX_VALUES-1:0] r_active, n_active;
    logic [mtpd_pkg::MASK_BITS-1:0]  r_m, n_m;
    logic [mtpd_pkg::MASK_BITS-1:0]  r_last_m, n_last_m;
    logic [mtpd_pkg::SUM_BITS-1:0]   r_best, n_best;
    logic                            r_have, n_have;
    logic                            r_np, n_np;
    logic [mtpd_pkg::OUT_BITS-1:0]   r_res_tot, n_res_tot;
    logic                            r_res_ovf, n_res_ovf;
    logic                            r_out_valid, n_out_valid;
    logic [mtpd_pkg::OUT_BITS-1:0]   r_out_min, n_out_min;
    logic [mtpd_pkg::OUT_BITS-1:0]   r_out_tot, n_out_tot;
    logic                            r_out_np, n_out_np;
    logic                            r_out_ovf, n_out_ovf;

    logic                            w_acc;
    logic                            w_room;
    logic [mtpd_pkg::STORE_BITS-1:0] w_value;
    logic [mtpd_pkg::CNT_BITS-1:0]   w_count_new;
    logic [mtpd_pkg::SUM_BITS-1:0]   w_total_new;
    logic                            w_ovf_new;
    logic [mtpd_pkg::DIFF_BITS-1:0]  w_abs_full;
    logic [mtpd_pkg::SUM_BITS-1:0]   w_abs;

    // Next state, loading, split walk and min tracking
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_active    = r_active;
        n_m         = r_m;
        n_last_m    = r_last_m;
        n_best      = r_best;
        n_have      = r_have;
        n_np        = r_np;
        n_res_tot   = r_res_tot;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid;
        n_out_min   = r_out_min;
        n_out_tot   = r_out_tot;
        n_out_np    = r_out_np;
        n_out_ovf   = r_out_ovf;

        o_stall = (r_state != mtpd_pkg::ST_LOAD);
        w_acc   = i_valid && !o_stall;
        w_room  = (r_count != mtpd_pkg::CNT_BITS'(mtpd_pkg::MAX_VALUES));
        w_value = i_value[mtpd_pkg::STORE_BITS-1:0];

        w_count_new = r_count + mtpd_pkg::CNT_BITS'(w_room);
        w_total_new = w_room ? r_total + mtpd_pkg::SUM_BITS'(w_value) : r_total;
        w_ovf_new   = r_ovf || !w_room;

        o_load.en    = w_acc && w_room;
        o_load.idx   = r_count[mtpd_pkg::IDX_BITS-1:0];
        o_load.value = w_value;

        o_tok.valid = 1'b0;
        o_tok.last  = (r_m == r_last_m);
        o_tok.mask  = {r_m, 1'b0};
        o_tok.diff  = '0;

        // magnitude of the difference leaving the chain
        w_abs_full = i_tok.diff[mtpd_pkg::DIFF_BITS-1] ? (~i_tok.diff + 1'b1) : i_tok.diff;
        w_abs      = w_abs_full[mtpd_pkg::SUM_BITS-1:0];

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // keep the smallest difference seen
        if (i_tok.valid) begin
            if (!r_have || (w_abs < r_best)) begin
                n_best = w_abs;
                n_have = 1'b1;
            end
        end

        unique case (r_state)
            mtpd_pkg::ST_LOAD: begin
                if (w_acc) begin
                    n_count = w_count_new;
                    n_total = w_total_new;
                    n_ovf   = w_ovf_new;
                    if (w_room) begin
                        n_active[o_load.idx] = 1'b1;
                    end
                    if (i_last) begin
                        n_res_tot = mtpd_pkg::sat_out(w_total_new);
                        n_res_ovf = w_ovf_new;
                        n_m       = mtpd_pkg::MASK_BITS'(1);
                        n_last_m  = mtpd_pkg::MASK_ONES >>
                                    (mtpd_pkg::CNT_BITS'(mtpd_pkg::MAX_VALUES) - w_count_new);
                        n_have    = 1'b0;
                        if (r_count == '0) begin
                            // single value: no split exists
                            n_best  = '0;
                            n_np    = 1'b1;
                            n_state = mtpd_pkg::ST_DONE;
                        end else begin
                            n_np    = 1'b0;
                            n_state = mtpd_pkg::ST_SWEEP;
                        end
                    end
                end
            end
            mtpd_pkg::ST_SWEEP: begin
                o_tok.valid = 1'b1;
                n_m         = r_m + 1'b1;
                if (o_tok.last) begin
                    n_state = mtpd_pkg::ST_DRAIN;
                end
            end
            mtpd_pkg::ST_DRAIN: begin
                if (i_tok.valid && i_tok.last) begin
                    n_state = mtpd_pkg::ST_DONE;
                end
            end
            mtpd_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_min   = mtpd_pkg::sat_out(r_best);
                    n_out_tot   = r_res_tot;
                    n_out_np    = r_np;
                    n_out_ovf   = r_res_ovf;
                    n_count     = '0;
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_active    = '0;
                    n_state     = mtpd_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = mtpd_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtpd_pkg::ST_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_last_m  <= n_last_m;
        r_best    <= n_best;
        r_have    <= n_have;
        r_np      <= n_np;
        r_res_tot <= n_res_tot;
        r_res_ovf <= n_res_ovf;
        r_out_min <= n_out_min;
        r_out_tot <= n_out_tot;
        r_out_np  <= n_out_np;
        r_out_ovf <= n_out_ovf;
    end

    assign o_active         = r_active;
    assign o_valid          = r_out_valid;
    assign o_min_difference = r_out_min;
    assign o_total_sum      = r_out_tot;
    assign o_no_partition   = r_out_np;
    assign o_count_overflow = r_out_ovf;

endmodule

`default_nettype wire

// File: rtl/min_two_way_partition_difference_unit.sv
// ----------------------------------------------------------------------------
// min_two_way_partition_difference_unit
// Top level: sequencer plus a chain of value cells that evaluates one split
// of the loaded set per cycle.
// ----------------------------------------------------------------------------
// Values are taken one per cycle until the request marked last; each of the first
// ten values lands in its own cell of a ten-cell chain. The unit then walks every
// split with the first value fixed in group one, issuing one split per cycle into
// the chain, where each cell adds or subtracts its value and passes the
// partial difference on. A set of n values (n >= 2) is loaded, walked through
// its 2^(n-1)-1 splits and drained from the chain before the result register
// is written; the split walk dominates. A single-value set goes straight to
// the result register without a walk. New values are taken while a finished
// result waits at the output, but not during the walk.
`default_nettype none

module min_two_way_partition_difference_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [mtpd_pkg::IN_BITS-1:0] i_value,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [mtpd_pkg::OUT_BITS-1:0]     o_min_difference,
    output logic [mtpd_pkg::OUT_BITS-1:0]     o_total_sum,
    output logic                              o_no_partition,
    output logic                              o_count_overflow
);

    mtpd_pkg::t_load                 w_load;
    logic [mtpd_pkg::MAX_VALUES-1:0] w_active;
    logic [mtpd_pkg::MAX_VALUES-1:0] w_wr_en;
    mtpd_pkg::t_token                w_tok [mtpd_pkg::MAX_VALUES+1];

    mtpd_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_min_difference (o_min_difference),
        .o_total_sum      (o_total_sum),
        .o_no_partition   (o_no_partition),
        .o_count_overflow (o_count_overflow),
        .o_load           (w_load),
        .o_active         (w_active),
        .o_tok            (w_tok[0]),
        .i_tok            (w_tok[mtpd_pkg::MAX_VALUES])
    );

    // Cell chain, one cell per value slot
    for (genvar k = 0; k < mtpd_pkg::MAX_VALUES; k++) begin : g_cell
        assign w_wr_en[k] = w_load.en && (w_load.idx == mtpd_pkg::IDX_BITS'(k));

        mtpd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en[k]),
            .i_wr_value (w_load.value),
            .i_active   (w_active[k]),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

endmodule

`default_nettype wire

// File: rtl/mtpd_checker.sv
// ----------------------------------------------------------------------------
// mtpd_checker
// Port-level checks for the minimum two-way partition difference unit,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic [mtpd_pkg::IN_BITS-1:0] i_value,
    input wire logic                         i_last,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [mtpd_pkg::OUT_BITS-1:0] o_min_difference,
    input wire logic [mtpd_pkg::OUT_BITS-1:0] o_total_sum,
    input wire logic                         o_no_partition,
    input wire logic                         o_count_overflow
);

    // No split: difference reads zero
    a_np_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_partition) |-> (o_min_difference == '0))
        else $error("no-partition result with nonzero difference");

    // Best difference never exceeds the total
    a_min_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_difference <= o_total_sum))
        else $error("difference exceeds total sum");

    // |total - 2*S| has the parity of the total when nothing saturates
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_no_partition && (o_total_sum != mtpd_pkg::OUT_MAX))
        |-> (o_min_difference[0] == o_total_sum[0]))
        else $error("difference parity does not match total");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_min_difference)
            && $stable(o_total_sum) && $stable(o_no_partition)
            && $stable(o_count_overflow)))
        else $error("stalled result changed");

    // Stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_value) && $stable(i_last)))
        else $error("stalled request changed");

endmodule

bind min_two_way_partition_difference_unit mtpd_checker u_mtpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_value          (i_value),
    .i_last           (i_last),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_min_difference (o_min_difference),
    .o_total_sum      (o_total_sum),
    .o_no_partition   (o_no_partition),
    .o_count_overflow (o_count_overflow)
);

`default_nettype wire
